// ===== sv/aar_pkg.sv =====
// shared constants and types of the adc average and resistance block
`timescale 1ns / 1ps

package aar_pkg;

    localparam int SAMPLE_W       = 12;
    localparam int LEN_W          = 9;
    localparam int SUM_W          = SAMPLE_W + LEN_W;
    localparam int AVG_W          = 12;
    localparam int MUL_A_W        = 36;
    localparam int MUL_B_W        = 24;
    localparam int PROD_W         = MUL_A_W + MUL_B_W;
    localparam int DIV_N_W        = 60;
    localparam int DIV_D_W        = 44;
    localparam int DIV_CNT_W      = $clog2(DIV_N_W + 1);
    localparam int AVG_STEPS      = SUM_W + 1;
    localparam int S_TDATA_W      = 16;
    localparam int M_TDATA_W      = 80;
    localparam int APB_ADDR_W     = 5;
    localparam int APB_DATA_W     = 32;

    localparam int WINDOW_MAX_DEF  = 256;
    localparam int SAMPLE_BITS_DEF = 12;
    localparam int CODE_LIMIT_DEF  = 4095;

    typedef enum logic [2:0] {
        REG_RPO     = 3'd0,
        REG_WIN     = 3'd1,
        REG_SCALE   = 3'd2,
        REG_MAXV    = 3'd3,
        REG_GAIN    = 3'd4,
        REG_CURRENT = 3'd5,
        REG_R1      = 3'd6,
        REG_R2      = 3'd7
    } reg_index_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    typedef struct packed {
        logic done;
        logic emit;
    } win_stat_t;

endpackage

// ===== sv/aar_window.sv =====
// sample ring with running sum and result pacing
`timescale 1ns / 1ps

module aar_window #(
    parameter int WINDOW_MAX = aar_pkg::WINDOW_MAX_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       restart,
    input  logic                       accept,
    input  logic [aar_pkg::SAMPLE_W-1:0] sample,
    input  logic [aar_pkg::LEN_W-1:0]  len,
    input  logic [aar_pkg::LEN_W-1:0]  rpo,
    output aar_pkg::win_stat_t         stat,
    output logic [aar_pkg::SUM_W-1:0]  sum
);
    import aar_pkg::*;

    localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CW = ((AW > LEN_W) ? AW : LEN_W) + 1;

    logic [SAMPLE_W-1:0] mem [WINDOW_MAX];
    logic [SAMPLE_W-1:0] old_reg;
    logic [SAMPLE_W-1:0] sample_reg;
    logic                update_reg;
    logic                done_reg;
    logic                emit_reg;
    logic                emit_next;
    logic [AW-1:0]       pos_reg;
    logic [AW-1:0]       pos_next;
    logic [SUM_W-1:0]    sum_reg;
    logic [SUM_W-1:0]    sum_next;
    logic                full_reg;
    logic                full_next;
    logic [LEN_W-1:0]    count_reg;
    logic [LEN_W-1:0]    count_next;
    logic [LEN_W-1:0]    count_inc;
    logic [LEN_W-1:0]    rpo_eff;
    logic [CW-1:0]       pos_inc;
    logic                wrap;

    always_ff @(posedge aclk) begin
        if (accept) begin
            old_reg    <= mem[pos_reg];
            sample_reg <= sample;
        end
        if (update_reg) begin
            mem[pos_reg] <= sample_reg;
        end
    end

    always_comb begin
        rpo_eff    = (rpo == '0) ? LEN_W'(1) : rpo;
        pos_inc    = CW'(pos_reg) + CW'(1);
        wrap       = pos_inc >= CW'(len);
        count_inc  = count_reg + LEN_W'(1);
        sum_next   = sum_reg;
        pos_next   = pos_reg;
        full_next  = full_reg;
        count_next = count_reg;
        emit_next  = 1'b0;
        if (!full_reg) begin
            sum_next = sum_reg + SUM_W'(sample_reg);
            if (wrap) begin
                pos_next   = '0;
                full_next  = 1'b1;
                count_next = '0;
                emit_next  = 1'b1;
            end else begin
                pos_next = AW'(pos_inc);
            end
        end else begin
            sum_next = sum_reg - SUM_W'(old_reg) + SUM_W'(sample_reg);
            pos_next = wrap ? '0 : AW'(pos_inc);
            if (count_inc >= rpo_eff) begin
                count_next = '0;
                emit_next  = 1'b1;
            end else begin
                count_next = count_inc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || restart) begin
            update_reg <= 1'b0;
            done_reg   <= 1'b0;
            emit_reg   <= 1'b0;
            pos_reg    <= '0;
            sum_reg    <= '0;
            full_reg   <= 1'b0;
            count_reg  <= '0;
        end else begin
            update_reg <= accept;
            done_reg   <= update_reg;
            if (update_reg) begin
                emit_reg  <= emit_next;
                pos_reg   <= pos_next;
                sum_reg   <= sum_next;
                full_reg  <= full_next;
                count_reg <= count_next;
            end
        end
    end

    assign stat.done = done_reg;
    assign stat.emit = emit_reg;
    assign sum       = sum_reg;

endmodule

// ===== sv/aar_mul.sv =====
// shared registered multiplier
`timescale 1ns / 1ps

module aar_mul (
    input  logic                        aclk,
    input  logic [aar_pkg::MUL_A_W-1:0] a,
    input  logic [aar_pkg::MUL_B_W-1:0] b,
    output logic [aar_pkg::PROD_W-1:0]  prod
);
    import aar_pkg::*;

    logic [PROD_W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= {{MUL_B_W{1'b0}}, a} * {{MUL_A_W{1'b0}}, b};
    end

    assign prod = prod_reg;

endmodule

// ===== sv/aar_div.sv =====
// shared restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module aar_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [aar_pkg::DIV_N_W-1:0]   num,
    input  logic [aar_pkg::DIV_D_W-1:0]   den,
    input  logic [aar_pkg::DIV_CNT_W-1:0] steps,
    output aar_pkg::div_stat_t            stat,
    output logic [aar_pkg::DIV_N_W-1:0]   quo,
    output logic [aar_pkg::DIV_D_W-1:0]   rem
);
    import aar_pkg::*;

    logic [DIV_N_W-1:0]   quo_reg;
    logic [DIV_D_W-1:0]   rem_reg;
    logic [DIV_D_W-1:0]   den_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_D_W:0]     trial;
    logic [DIV_D_W:0]     trial_sub;
    logic                 ge;

    assign trial     = {rem_reg, quo_reg[DIV_N_W-1]};
    assign trial_sub = trial - {1'b0, den_reg};
    assign ge        = trial >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= steps;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - DIV_CNT_W'(1);
                if (cnt_reg == DIV_CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end else if (busy_reg) begin
            rem_reg <= ge ? trial_sub[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
            quo_reg <= {quo_reg[DIV_N_W-2:0], ge};
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quo       = quo_reg;
    assign rem       = rem_reg;

endmodule

// ===== sv/adc_average_and_resistance_core.sv =====
// Top level: ADC window averager with voltmeter and ohmmeter conversion.
//
// Samples enter on the s_ stream (sample in s_tdata[11:0]); results leave on
// the m_ stream. Registers are written through the APB port at 4*index.
// Each sample goes into a ring of window_length entries with a running sum.
// The first result comes when the window is full, then one per
// readings_per_output samples. A result carries the rounded average, the
// voltage in microvolts, the ohmmeter resistance and a valid flag in tuser.
// An item that yields no result goes through the window update before the next
// one is taken. An item that yields a result also waits for the shared divider
// (22 steps for the average, 60 for the resistance when it is computed) and six
// passes through the shared multiplier before the next one is taken. s_tready is
// low meanwhile.
// A finished result sits in the output register; the next sample is taken
// while it waits, and the sequencer holds before loading a new result until
// the receiver has taken the old one.
// Reset restores the register defaults and empties the window; writing
// readings_per_output or window_length also empties the window.
`timescale 1ns / 1ps

module adc_average_and_resistance_core #(
    parameter int WINDOW_MAX  = aar_pkg::WINDOW_MAX_DEF,
    parameter int SAMPLE_BITS = aar_pkg::SAMPLE_BITS_DEF,
    parameter int CODE_LIMIT  = aar_pkg::CODE_LIMIT_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [aar_pkg::S_TDATA_W-1:0]  s_tdata,   // sample[11:0], zero pad
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // average_code[11:0], voltage_uv[43:12], resistance_ohm[75:44], zero pad
    output logic [aar_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic [0:0]                     m_tuser,   // valid_res[0]
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [aar_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [aar_pkg::APB_DATA_W-1:0] pwdata,
    output logic [aar_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);
    import aar_pkg::*;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_WIN   = 4'd1;
    localparam logic [3:0] ST_DIVA  = 4'd2;
    localparam logic [3:0] ST_MU    = 4'd3;
    localparam logic [3:0] ST_MLIM  = 4'd4;
    localparam logic [3:0] ST_MVOLT = 4'd5;
    localparam logic [3:0] ST_MCUR  = 4'd6;
    localparam logic [3:0] ST_MIR   = 4'd7;
    localparam logic [3:0] ST_MNUM  = 4'd8;
    localparam logic [3:0] ST_CHECK = 4'd9;
    localparam logic [3:0] ST_DIVR  = 4'd10;
    localparam logic [3:0] ST_RND   = 4'd11;
    localparam logic [3:0] ST_OUT   = 4'd12;

    localparam logic [SAMPLE_W-1:0] SAMPLE_MASK =
        SAMPLE_W'((64'd1 << SAMPLE_BITS) - 64'd1);
    localparam logic [MUL_B_W-1:0] K_THOUSAND = MUL_B_W'(1000);

    // configuration registers
    logic [8:0]  rpo_reg;
    logic [8:0]  win_reg;
    logic [23:0] scale_reg;
    logic [23:0] maxv_reg;
    logic [31:0] gain_reg;
    logic [9:0]  current_reg;
    logic [23:0] r1_reg;
    logic [23:0] r2_reg;
    logic        cfg_we;
    logic [2:0]  cfg_idx;
    logic        restart;

    logic [3:0]  state_reg;
    logic [3:0]  state_next;

    logic [LEN_W-1:0]   len_eff;
    win_stat_t          win_stat;
    logic [SUM_W-1:0]   win_sum;
    logic               accept;

    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [PROD_W-1:0]  prod;

    logic               div_start;
    logic [DIV_N_W-1:0] div_num;
    logic [DIV_D_W-1:0] div_den;
    logic [DIV_CNT_W-1:0] div_steps;
    div_stat_t          div_stat;
    logic [DIV_N_W-1:0] div_quo;
    logic [DIV_D_W-1:0] div_rem;

    logic [SUM_W:0]     sum_round;
    logic [DIV_D_W-1:0] u_ext;
    logic [DIV_D_W-1:0] den_r;
    logic [DIV_D_W:0]   vsum;
    logic               valid_now;
    logic [DIV_N_W:0]   res_sum;
    logic               out_load;

    logic [AVG_W-1:0]   avg_reg;
    logic [MUL_A_W-1:0] u_reg;
    logic [33:0]        lim_reg;
    logic [DIV_D_W-1:0] ir_reg;
    logic [31:0]        volt_reg;
    logic [31:0]        res_reg;
    logic               valid_reg;
    logic [DIV_N_W-1:0] diff_reg;
    logic               neg_reg;
    logic               rnd_reg;

    logic               m_tvalid_reg;
    logic [AVG_W-1:0]   m_avg_reg;
    logic [31:0]        m_volt_reg;
    logic [31:0]        m_res_reg;
    logic               m_valid_reg;

    // configuration port
    assign pready  = 1'b1;
    assign cfg_idx = paddr[4:2];
    assign cfg_we  = psel && penable && pwrite;
    assign restart = cfg_we && (cfg_idx == REG_RPO || cfg_idx == REG_WIN);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rpo_reg     <= 9'd1;
            win_reg     <= 9'd16;
            scale_reg   <= 24'd1000000;
            maxv_reg    <= 24'd3300000;
            gain_reg    <= 32'd65536000;
            current_reg <= 10'd40;
            r1_reg      <= 24'd1000000;
            r2_reg      <= 24'd0;
        end else if (cfg_we) begin
            unique case (cfg_idx)
                REG_RPO:     rpo_reg     <= pwdata[8:0];
                REG_WIN:     win_reg     <= pwdata[8:0];
                REG_SCALE:   scale_reg   <= pwdata[23:0];
                REG_MAXV:    maxv_reg    <= pwdata[23:0];
                REG_GAIN:    gain_reg    <= pwdata;
                REG_CURRENT: current_reg <= pwdata[9:0];
                REG_R1:      r1_reg      <= pwdata[23:0];
                REG_R2:      r2_reg      <= pwdata[23:0];
                default:     ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_RPO:     prdata = 32'(rpo_reg);
            REG_WIN:     prdata = 32'(win_reg);
            REG_SCALE:   prdata = 32'(scale_reg);
            REG_MAXV:    prdata = 32'(maxv_reg);
            REG_GAIN:    prdata = gain_reg;
            REG_CURRENT: prdata = 32'(current_reg);
            REG_R1:      prdata = 32'(r1_reg);
            REG_R2:      prdata = 32'(r2_reg);
            default:     prdata = '0;
        endcase
    end

    always_comb begin
        if (win_reg == '0) begin
            len_eff = LEN_W'(1);
        end else if (32'(win_reg) > 32'(WINDOW_MAX)) begin
            len_eff = LEN_W'(WINDOW_MAX);
        end else begin
            len_eff = win_reg;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    aar_window #(
        .WINDOW_MAX (WINDOW_MAX)
    ) u_window (
        .aclk    (aclk),
        .aresetn (aresetn),
        .restart (restart),
        .accept  (accept),
        .sample  (s_tdata[SAMPLE_W-1:0] & SAMPLE_MASK),
        .len     (len_eff),
        .rpo     (rpo_reg),
        .stat    (win_stat),
        .sum     (win_sum)
    );

    aar_mul u_mul (
        .aclk (aclk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    aar_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .steps   (div_steps),
        .stat    (div_stat),
        .quo     (div_quo),
        .rem     (div_rem)
    );

    assign sum_round = {1'b0, win_sum} + (SUM_W + 1)'(len_eff >> 1);
    assign u_ext     = DIV_D_W'(u_reg);
    assign den_r     = ir_reg - u_ext;
    assign vsum      = {1'b0, prod[DIV_D_W-1:0]} + (DIV_D_W + 1)'(32768);
    assign valid_now = (32'(avg_reg) < 32'(CODE_LIMIT)) && (MUL_A_W'(lim_reg) >= u_reg);
    assign res_sum   = {1'b0, diff_reg} + (DIV_N_W + 1)'(rnd_reg);
    assign out_load  = (state_reg == ST_OUT) && (!m_tvalid_reg || m_tready);

    // sequencer
    always_comb begin
        state_next = state_reg;
        div_start  = 1'b0;
        div_num    = prod;
        div_den    = den_r;
        div_steps  = DIV_CNT_W'(DIV_N_W);
        mul_a      = '0;
        mul_b      = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_WIN;
                end
            end
            ST_WIN: begin
                div_num   = {sum_round, {(DIV_N_W - AVG_STEPS){1'b0}}};
                div_den   = DIV_D_W'(len_eff);
                div_steps = DIV_CNT_W'(AVG_STEPS);
                if (win_stat.done) begin
                    if (win_stat.emit) begin
                        div_start  = 1'b1;
                        state_next = ST_DIVA;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_DIVA: begin
                if (div_stat.done) begin
                    state_next = ST_MU;
                end
            end
            ST_MU: begin
                mul_a      = MUL_A_W'(scale_reg);
                mul_b      = MUL_B_W'(avg_reg);
                state_next = ST_MLIM;
            end
            ST_MLIM: begin
                mul_a      = MUL_A_W'(maxv_reg);
                mul_b      = K_THOUSAND;
                state_next = ST_MVOLT;
            end
            ST_MVOLT: begin
                mul_a      = MUL_A_W'(gain_reg);
                mul_b      = MUL_B_W'(avg_reg);
                state_next = ST_MCUR;
            end
            ST_MCUR: begin
                mul_a      = MUL_A_W'(current_reg);
                mul_b      = K_THOUSAND;
                state_next = ST_MIR;
            end
            ST_MIR: begin
                mul_a      = prod[MUL_A_W-1:0];
                mul_b      = r1_reg;
                state_next = ST_MNUM;
            end
            ST_MNUM: begin
                mul_a      = u_reg;
                mul_b      = r1_reg;
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                if (valid_now && u_reg != '0 && ir_reg > u_ext) begin
                    div_start  = 1'b1;
                    state_next = ST_DIVR;
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_DIVR: begin
                if (div_stat.done) begin
                    state_next = ST_RND;
                end
            end
            ST_RND: begin
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_DIVA: begin
                if (div_stat.done) begin
                    avg_reg <= div_quo[AVG_W-1:0];
                end
            end
            ST_MLIM: begin
                u_reg <= prod[MUL_A_W-1:0];
            end
            ST_MVOLT: begin
                lim_reg <= prod[33:0];
            end
            ST_MCUR: begin
                volt_reg <= 32'(vsum[DIV_D_W:16]);
            end
            ST_MNUM: begin
                ir_reg <= prod[DIV_D_W-1:0];
            end
            ST_CHECK: begin
                valid_reg <= valid_now;
                if (!valid_now) begin
                    volt_reg <= '0;
                    res_reg  <= '0;
                end else if (u_reg == '0) begin
                    res_reg <= '0;
                end else if (ir_reg == u_ext) begin
                    res_reg <= '1;
                end else if (ir_reg < u_ext) begin
                    res_reg <= '0;
                end
            end
            ST_DIVR: begin
                if (div_stat.done) begin
                    neg_reg  <= div_quo < DIV_N_W'(r2_reg);
                    diff_reg <= div_quo - DIV_N_W'(r2_reg);
                    rnd_reg  <= {div_rem, 1'b0} >= {1'b0, den_r};
                end
            end
            ST_RND: begin
                if (neg_reg) begin
                    res_reg <= '0;
                end else if (|res_sum[DIV_N_W:32]) begin
                    res_reg <= '1;
                end else begin
                    res_reg <= res_sum[31:0];
                end
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_avg_reg   <= avg_reg;
            m_volt_reg  <= volt_reg;
            m_res_reg   <= res_reg;
            m_valid_reg <= valid_reg;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = {4'b0, m_res_reg, m_volt_reg, m_avg_reg};
    assign m_tuser[0] = m_valid_reg;

    a_win_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        win_stat.done |-> state_reg == ST_WIN)
        else $error("window result outside wait state");

    a_div_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_stat.busy)
        else $error("divider started while busy");

    a_div_wait_live: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIVA || state_reg == ST_DIVR) |-> div_stat.busy || div_stat.done)
        else $error("waiting on an idle divider");

    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> m_tdata[75:12] == '0)
        else $error("invalid result carries nonzero voltage or resistance");

    a_ready_div_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !div_stat.busy)
        else $error("input taken while divider busy");

endmodule
